>>> hw/rtl/snes_pad_shift_reader_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pad shift reader
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SNES_PAD_SHIFT_READER_UNIT_MACROS_SVH
`define SNES_PAD_SHIFT_READER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define SPSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPSR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SPSR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> hw/rtl/spsr_pkg.sv
// ----------------------------------------------------------------------------
// Pad shift reader package
// Widths, codes and the poll record shared by the reader modules.
// ----------------------------------------------------------------------------
package spsr_pkg;

    localparam int LANES        = 4;
    localparam int LANE_W       = 2;
    localparam int MAX_PADS_DEF = 4;
    localparam int SLOTS_SNES   = 12;
    localparam int SLOTS_NES    = 8;
    localparam int SLOT_W       = 4;
    localparam int WORD_W       = 12;
    localparam int PADS_W       = 3;
    localparam int BIT_UP       = 4;
    localparam int BIT_DOWN     = 5;
    localparam int BIT_LEFT     = 6;
    localparam int BIT_RIGHT    = 7;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 3;

    typedef enum logic [1:0] {
        AXIS_ORIGIN = 2'd0,
        AXIS_HIGH   = 2'd1,
        AXIS_LOW    = 2'd2
    } axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAD_TYPE    = 1'b0,
        REG_PADS_IN_USE = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        PAD_NES  = 1'b0,
        PAD_SNES = 1'b1
    } pad_type_t;

    typedef struct packed {
        pad_type_t         pad_type;
        logic [PADS_W-1:0] pads_in_use;
    } cfg_t;

    typedef struct packed {
        logic [LANES-1:0][WORD_W-1:0] words;
        logic [PADS_W-1:0]            npads;
    } poll_rec_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

endpackage

>>> hw/rtl/spsr_front.sv
// ----------------------------------------------------------------------------
// Pad shift reader front end
// Accepts one sampled slot per request, builds the per-pad words and hands a
// finished poll to the queue.
// ----------------------------------------------------------------------------
module spsr_front #(
    parameter int MAX_PADS = spsr_pkg::MAX_PADS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spsr_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           data_levels,
    input  logic                 first_slot,
    output spsr_pkg::queue_wr_t  q_wr,
    input  logic                 q_full,
    output spsr_pkg::poll_rec_t  rec
);

    `include "snes_pad_shift_reader_unit_macros.svh"

    localparam int NLANES = (MAX_PADS < spsr_pkg::LANES) ? MAX_PADS : spsr_pkg::LANES;

    logic [spsr_pkg::WORD_W-1:0] shift_reg  [NLANES];
    logic [spsr_pkg::WORD_W-1:0] shift_next [NLANES];
    logic [spsr_pkg::SLOT_W-1:0] slot_count_reg, slot_count_next;

    logic [spsr_pkg::SLOT_W-1:0] slot_eff;
    logic [spsr_pkg::SLOT_W-1:0] nslots;
    logic [spsr_pkg::WORD_W-1:0] mask;
    logic [spsr_pkg::PADS_W-1:0] npads;
    logic                        ends_poll;
    logic                        accept;

    always_comb begin
        if (cfg.pads_in_use == '0) begin
            npads = spsr_pkg::PADS_W'(1);
        end else if (cfg.pads_in_use > spsr_pkg::PADS_W'(NLANES)) begin
            npads = spsr_pkg::PADS_W'(NLANES);
        end else begin
            npads = cfg.pads_in_use;
        end
    end

    assign nslots    = (cfg.pad_type == spsr_pkg::PAD_SNES) ?
                       spsr_pkg::SLOT_W'(spsr_pkg::SLOTS_SNES) :
                       spsr_pkg::SLOT_W'(spsr_pkg::SLOTS_NES);
    assign mask      = (cfg.pad_type == spsr_pkg::PAD_SNES) ?
                       {spsr_pkg::WORD_W{1'b1}} :
                       spsr_pkg::WORD_W'({spsr_pkg::SLOTS_NES{1'b1}});
    assign slot_eff  = first_slot ? '0 : slot_count_reg;
    assign ends_poll = ({1'b0, slot_eff} + 5'd1) >= {1'b0, nslots};
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    assign q_wr.push = accept && ends_poll;
    assign q_wr.full = q_full;

    always_comb begin
        logic [spsr_pkg::WORD_W-1:0] base;
        logic [spsr_pkg::WORD_W-1:0] built;
        rec.words       = '0;
        rec.npads       = npads;
        slot_count_next = slot_count_reg;
        for (int p = 0; p < NLANES; p++) begin
            base  = first_slot ? '0 : shift_reg[p];
            built = base;
            if (spsr_pkg::PADS_W'(p) < npads && !data_levels[p] &&
                slot_eff < spsr_pkg::SLOT_W'(spsr_pkg::SLOTS_SNES)) begin
                built = base | (spsr_pkg::WORD_W'(1) << slot_eff);
            end
            rec.words[p] = built & mask;
            shift_next[p] = shift_reg[p];
            if (accept) begin
                if (ends_poll && spsr_pkg::PADS_W'(p) < npads) begin
                    shift_next[p] = '0;
                end else if (ends_poll) begin
                    shift_next[p] = base;
                end else begin
                    shift_next[p] = built;
                end
            end
        end
        if (accept) begin
            slot_count_next = ends_poll ? '0 : slot_eff + spsr_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= '0;
            for (int p = 0; p < NLANES; p++) begin
                shift_reg[p] <= '0;
            end
        end else begin
            slot_count_reg <= slot_count_next;
            for (int p = 0; p < NLANES; p++) begin
                shift_reg[p] <= shift_next[p];
            end
        end
    end

    `SPSR_ASSERT_IMP(a_slot_range, aclk, aresetn, 1'b1,
        slot_count_reg < spsr_pkg::SLOT_W'(spsr_pkg::SLOTS_SNES),
        "slot counter ran past the longest poll")

endmodule

>>> hw/rtl/spsr_queue.sv
// ----------------------------------------------------------------------------
// Pad shift reader poll queue
// Short queue of finished polls between the front end and the result builder.
// ----------------------------------------------------------------------------
module spsr_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spsr_pkg::queue_wr_t  q_wr,
    input  spsr_pkg::poll_rec_t  rec_in,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output spsr_pkg::poll_rec_t  head
);

    `include "snes_pad_shift_reader_unit_macros.svh"

    localparam int PTR_W = (spsr_pkg::QUEUE_DEPTH > 1) ? $clog2(spsr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(spsr_pkg::QUEUE_DEPTH + 1);

    spsr_pkg::poll_rec_t mem_reg [spsr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = count_reg == CNT_W'(spsr_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = q_wr.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(spsr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(spsr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= rec_in;
        end
    end

    `SPSR_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CNT_W'(spsr_pkg::QUEUE_DEPTH),
        "poll queue count exceeds its depth")
    `SPSR_ASSERT_IMP(a_no_drop, aclk, aresetn, q_wr.push, !q_wr.full,
        "finished poll offered while the queue is full")

endmodule

>>> hw/rtl/spsr_back.sv
// ----------------------------------------------------------------------------
// Pad shift reader result builder
// Walks the pads of the poll at the queue head, one result per cycle while
// the output is not stalled, and keeps the last reported word of every pad.
// ----------------------------------------------------------------------------
module spsr_back #(
    parameter int MAX_PADS = spsr_pkg::MAX_PADS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  spsr_pkg::poll_rec_t           head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    pad_index,
    output logic [spsr_pkg::WORD_W-1:0]   buttons,
    output logic                          report,
    output logic                          noise,
    output spsr_pkg::axis_t               x_axis,
    output spsr_pkg::axis_t               y_axis,
    output logic                          last_pad
);

    `include "snes_pad_shift_reader_unit_macros.svh"

    localparam int NLANES = (MAX_PADS < spsr_pkg::LANES) ? MAX_PADS : spsr_pkg::LANES;
    localparam int IDX_W  = (NLANES > 1) ? $clog2(NLANES) : 1;

    logic [spsr_pkg::WORD_W-1:0] prev_reg [NLANES];
    logic [IDX_W-1:0]            pad_idx_reg, pad_idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  pad_index_reg;
    logic [spsr_pkg::WORD_W-1:0] buttons_reg;
    logic                        report_reg;
    logic                        noise_reg;
    spsr_pkg::axis_t             x_axis_reg;
    spsr_pkg::axis_t             y_axis_reg;
    logic                        last_pad_reg;

    logic [spsr_pkg::WORD_W-1:0] word;
    logic [spsr_pkg::WORD_W-1:0] stored;
    logic                        up, down, left, right;
    logic                        noisy, changed, is_last, load;
    spsr_pkg::axis_t             x_code, y_code;

    assign word    = head.words[spsr_pkg::LANE_W'(pad_idx_reg)];
    assign up      = word[spsr_pkg::BIT_UP];
    assign down    = word[spsr_pkg::BIT_DOWN];
    assign left    = word[spsr_pkg::BIT_LEFT];
    assign right   = word[spsr_pkg::BIT_RIGHT];
    assign noisy   = (up && down) || (left && right);
    assign changed = word != prev_reg[pad_idx_reg];
    assign stored  = noisy ? '0 : word;
    assign is_last = (spsr_pkg::PADS_W'(pad_idx_reg) + spsr_pkg::PADS_W'(1)) == head.npads;
    assign x_code  = left ? spsr_pkg::AXIS_HIGH : (right ? spsr_pkg::AXIS_LOW : spsr_pkg::AXIS_ORIGIN);
    assign y_code  = up ? spsr_pkg::AXIS_HIGH : (down ? spsr_pkg::AXIS_LOW : spsr_pkg::AXIS_ORIGIN);
    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign pop     = load && is_last;

    always_comb begin
        pad_idx_next   = pad_idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
            pad_idx_next   = is_last ? '0 : pad_idx_reg + IDX_W'(1);
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NLANES; p++) begin
                prev_reg[p] <= '0;
            end
        end else begin
            pad_idx_reg   <= pad_idx_next;
            out_valid_reg <= out_valid_next;
            if (load) begin
                prev_reg[pad_idx_reg] <= stored;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pad_index_reg <= 2'(pad_idx_reg);
            buttons_reg   <= stored;
            report_reg    <= changed && !noisy;
            noise_reg     <= noisy;
            x_axis_reg    <= x_code;
            y_axis_reg    <= y_code;
            last_pad_reg  <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pad_index = pad_index_reg;
    assign buttons   = buttons_reg;
    assign report    = report_reg;
    assign noise     = noise_reg;
    assign x_axis    = x_axis_reg;
    assign y_axis    = y_axis_reg;
    assign last_pad  = last_pad_reg;

    `SPSR_ASSERT_IMP(a_noise_zero, aclk, aresetn, out_valid_reg && noise_reg,
        (buttons_reg == '0) && !report_reg,
        "noisy result carries buttons or a report")
    `SPSR_ASSERT_IMP(a_idx_range, aclk, aresetn, head_valid,
        spsr_pkg::PADS_W'(pad_idx_reg) < head.npads,
        "pad walk ran past the pads of the poll")

endmodule

>>> hw/rtl/snes_pad_shift_reader_unit.sv
// ----------------------------------------------------------------------------
// NES/SNES pad shift reader
// Collects sampled data-line slots of up to four pads and reports each poll.
// ----------------------------------------------------------------------------
// Each request on the slave side is one sampled bit slot, so a slot may
// arrive every cycle. After the last slot of a poll (8 for NES, 12 for
// SNES) the finished words go into a two-entry queue, and the result
// builder then sends one result per pad in use, one per cycle unless
// m_tready is low, with tlast on the final pad. The slave side stalls
// only while that queue holds two finished polls.
module snes_pad_shift_reader_unit #(
    parameter int MAX_PADS = spsr_pkg::MAX_PADS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [spsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [3:0] data_levels, [7:4] zero
    input  logic                           s_tuser,   // [0] first_slot
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [1:0] pad_index, [13:2] buttons,
                                                      // [14] report, [15] noise,
                                                      // [17:16] x_axis, [19:18] y_axis,
                                                      // [23:20] zero
    output logic                           m_tlast    // last_pad
);

    spsr_pkg::cfg_t      cfg_reg;
    spsr_pkg::queue_wr_t q_wr;
    spsr_pkg::poll_rec_t rec;
    spsr_pkg::poll_rec_t head;
    logic                q_full;
    logic                head_valid;
    logic                pop;
    logic [1:0]          pad_index;
    logic [spsr_pkg::WORD_W-1:0] buttons;
    logic                report;
    logic                noise;
    spsr_pkg::axis_t     x_axis;
    spsr_pkg::axis_t     y_axis;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pad_type    <= spsr_pkg::PAD_SNES;
            cfg_reg.pads_in_use <= spsr_pkg::PADS_W'(1);
        end else if (cfg_wr_en) begin
            unique case (spsr_pkg::cfg_reg_t'(cfg_index))
                spsr_pkg::REG_PAD_TYPE: begin
                    cfg_reg.pad_type <= spsr_pkg::pad_type_t'(cfg_wdata[0]);
                end
                spsr_pkg::REG_PADS_IN_USE: begin
                    cfg_reg.pads_in_use <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    spsr_front #(
        .MAX_PADS (MAX_PADS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .data_levels (s_tdata[3:0]),
        .first_slot  (s_tuser),
        .q_wr        (q_wr),
        .q_full      (q_full),
        .rec         (rec)
    );

    spsr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_wr       (q_wr),
        .rec_in     (rec),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    spsr_back #(
        .MAX_PADS (MAX_PADS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .pad_index  (pad_index),
        .buttons    (buttons),
        .report     (report),
        .noise      (noise),
        .x_axis     (x_axis),
        .y_axis     (y_axis),
        .last_pad   (m_tlast)
    );

    assign m_tdata = {4'b0000, y_axis, x_axis, noise, report, buttons, pad_index};

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pad shift reader testbench
// Streams sampled data-line slots into the reader under several pad types and
// pad counts, predicts every per-pad poll result in step with the accepted
// requests, and compares each delivered result field by field. Well-formed
// latched polls dominate, mixed with unlatched, cut-short and random slots.
// ----------------------------------------------------------------------------
module tb;
    import spsr_pkg::*;

    localparam int MAX_PADS      = MAX_PADS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SEGMENTS      = 12;
    localparam int SEG_SLOTS     = 12;
    localparam int PRINT_CAP     = 40;

    typedef struct {
        logic [LANES-1:0] levels;
        logic             first;
        bit               wait_empty;
    } slot_req_t;

    typedef struct {
        logic [LANE_W-1:0] pad_index;
        logic [WORD_W-1:0] buttons;
        logic              report;
        logic              noise;
        axis_t             x_axis;
        axis_t             y_axis;
        logic              last_pad;
    } pad_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PAD_TYPE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tlast;

    slot_req_t   slot_queue[$];
    pad_result_t pad_results_due[$];

    // Shadow of the reader state and its registers.
    logic [WORD_W-1:0] build_word[LANES];
    logic [WORD_W-1:0] last_word[LANES];
    logic [SLOT_W-1:0] slot_pos;
    pad_type_t         cur_type;
    logic [PADS_W-1:0] cur_pads;

    logic [WORD_W-1:0] gen_word[LANES];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int slots_sent    = 0;
    int polls_done    = 0;
    int results_seen  = 0;
    int settings_used = 0;

    snes_pad_shift_reader_unit #(.MAX_PADS(MAX_PADS)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pads_active(input logic [PADS_W-1:0] n);
        int cap = (MAX_PADS < LANES) ? MAX_PADS : LANES;
        int k;
        k = (n == 0) ? 1 : int'(n);
        return (k > cap) ? cap : k;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    task automatic predict_slot(input logic [LANES-1:0] levels, input logic first);
        int                nslots;
        int                npads;
        logic [WORD_W-1:0] keep;
        logic [WORD_W-1:0] w;
        logic              up, down, left, right, noisy;
        pad_result_t       r;
        nslots = (cur_type == PAD_SNES) ? SLOTS_SNES : SLOTS_NES;
        npads  = pads_active(cur_pads);
        if (first) begin
            for (int p = 0; p < LANES; p++)
                build_word[p] = '0;
            slot_pos = '0;
        end
        for (int p = 0; p < npads; p++)
            if (!levels[p] && slot_pos < SLOTS_SNES)
                build_word[p][slot_pos] = 1'b1;
        if (int'(slot_pos) + 1 < nslots) begin
            slot_pos = slot_pos + 1'b1;
        end else begin
            keep = {WORD_W{1'b1}} >> (WORD_W - nslots);
            for (int p = 0; p < npads; p++) begin
                w     = build_word[p] & keep;
                up    = w[BIT_UP];
                down  = w[BIT_DOWN];
                left  = w[BIT_LEFT];
                right = w[BIT_RIGHT];
                noisy = (up & down) | (left & right);
                r.pad_index = LANE_W'(p);
                r.buttons   = noisy ? '0 : w;
                r.report    = (w != last_word[p]) && !noisy;
                r.noise     = noisy;
                r.x_axis    = left ? AXIS_HIGH : (right ? AXIS_LOW : AXIS_ORIGIN);
                r.y_axis    = up ? AXIS_HIGH : (down ? AXIS_LOW : AXIS_ORIGIN);
                r.last_pad  = (p + 1 == npads);
                last_word[p]  = noisy ? '0 : w;
                build_word[p] = '0;
                pad_results_due.push_back(r);
            end
            slot_pos = '0;
            polls_done++;
        end
    endtask

    always @(posedge aclk) begin : slot_driver
        slot_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_slot(s_tdata[LANES-1:0], s_tuser);
                slots_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (slot_queue.size() != 0
                    && !(slot_queue[0].wait_empty && pad_results_due.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = slot_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= 8'(nxt.levels);
                    s_tuser  <= nxt.first;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        pad_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pad_results_due.size() == 0) begin
                    report_mismatch("result with nothing pending", int'(m_tdata), 0);
                end else begin
                    want = pad_results_due.pop_front();
                    check_field("pad_index", m_tdata[1:0], want.pad_index);
                    check_field("buttons", m_tdata[13:2], want.buttons);
                    check_field("report", m_tdata[14], want.report);
                    check_field("noise", m_tdata[15], want.noise);
                    check_field("x_axis", m_tdata[17:16], want.x_axis);
                    check_field("y_axis", m_tdata[19:18], want.y_axis);
                    check_field("last_pad", m_tlast, want.last_pad);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PAD_TYPE:    cur_type = pad_type_t'(val[0]);
            REG_PADS_IN_USE: cur_pads = val;
            default:         ;
        endcase
        settings_used++;
    endtask

    task automatic wait_quiet();
        int waited;
        waited = 0;
        while ((slot_queue.size() != 0 || s_tvalid || pad_results_due.size() != 0)
               && waited < QUIET_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (slot_queue.size() != 0 || s_tvalid) begin
            report_mismatch("requests never accepted", 0, slot_queue.size());
            slot_queue.delete();
        end
        if (pad_results_due.size() != 0) begin
            report_mismatch("results never delivered", 0, pad_results_due.size());
            pad_results_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_slot(input logic [LANES-1:0] levels, input logic first, input bit hold);
        slot_req_t q;
        q.levels     = levels;
        q.first      = first;
        q.wait_empty = hold;
        slot_queue.push_back(q);
    endtask

    // One slot per bit of gen_word, a low level where the button is pressed.
    task automatic queue_poll(input int count, input bit latch, input bit hold);
        logic [LANES-1:0] lv;
        for (int i = 0; i < count; i++) begin
            for (int p = 0; p < LANES; p++)
                lv[p] = ~gen_word[p][i];
            queue_slot(lv, latch && i == 0, hold && i == 0);
        end
    endtask

    task automatic fresh_words();
        int                kind;
        logic [WORD_W-1:0] w;
        for (int p = 0; p < LANES; p++) begin
            kind = $urandom_range(0, 9);
            w = '0;
            if (kind == 0) begin
                w = WORD_W'($urandom);
            end else if (kind == 1) begin
                w = WORD_W'($urandom) & WORD_W'($urandom);
                if ($urandom_range(0, 1)) begin
                    w[BIT_UP]   = 1'b1;
                    w[BIT_DOWN] = 1'b1;
                end else begin
                    w[BIT_LEFT]  = 1'b1;
                    w[BIT_RIGHT] = 1'b1;
                end
            end else if (kind != 2) begin
                for (int b = 0; b < WORD_W; b++)
                    w[b] = ($urandom_range(0, 7) == 0);
            end
            gen_word[p] = w;
        end
    endtask

    task automatic queue_segment();
        int nslots;
        int budget;
        int kind;
        int n;
        nslots = (cur_type == PAD_SNES) ? SLOTS_SNES : SLOTS_NES;
        budget = 0;
        if ($urandom_range(0, 1)) begin
            fresh_words();
            queue_poll(nslots, 1'b0, 1'b0);
            budget += nslots;
        end
        while (budget < SEG_SLOTS) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 3) != 0)
                fresh_words();
            if (kind < 7) begin
                queue_poll(nslots, 1'b1, $urandom_range(0, 19) == 0);
                budget += nslots;
            end else if (kind == 7) begin
                queue_poll(nslots, 1'b0, 1'b0);
                budget += nslots;
            end else if (kind == 8) begin
                n = $urandom_range(1, nslots - 1);
                queue_poll(n, 1'b1, 1'b0);
                budget += n;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) queue_slot(LANES'($urandom_range(0, 15)),
                                      1'($urandom_range(0, 1)), 1'b0);
                budget += n;
            end
        end
        // Leave a poll open (always for SNES, at random for NES) so that the next register write lands mid-poll.
        fresh_words();
        if (cur_type == PAD_SNES)
            queue_poll($urandom_range(SLOTS_NES, SLOTS_SNES - 1), 1'b1, 1'b0);
        else if ($urandom_range(0, 1))
            queue_poll($urandom_range(1, SLOTS_NES - 1), 1'b1, 1'b0);
    endtask

    initial begin
        for (int p = 0; p < LANES; p++) begin
            build_word[p] = '0;
            last_word[p]  = '0;
        end
        slot_pos = '0;
        cur_type = PAD_SNES;
        cur_pads = PADS_W'(1);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 67;
        write_reg(REG_PAD_TYPE, CFG_DATA_W'(PAD_NES));
        write_reg(REG_PADS_IN_USE, CFG_DATA_W'(LANES));

        // Up alone, up with down, left with right, and nothing pressed.
        gen_word[0] = WORD_W'(1) << BIT_UP;
        gen_word[1] = (WORD_W'(1) << BIT_UP) | (WORD_W'(1) << BIT_DOWN);
        gen_word[2] = (WORD_W'(1) << BIT_LEFT) | (WORD_W'(1) << BIT_RIGHT);
        gen_word[3] = '0;
        queue_poll(SLOTS_NES, 1'b1, 1'b0);
        // A latch in the middle of a poll throws the partial words away.
        gen_word[0] = (WORD_W'(1) << BIT_RIGHT) | WORD_W'(1);
        gen_word[1] = WORD_W'(1) << BIT_DOWN;
        gen_word[2] = {WORD_W{1'b1}};
        gen_word[3] = WORD_W'(1) << BIT_LEFT;
        queue_poll(2, 1'b1, 1'b0);
        queue_poll(SLOTS_NES, 1'b1, 1'b0);
        // Free-running poll with every button held, sent only once all
        // earlier results are out.
        for (int p = 0; p < LANES; p++)
            gen_word[p] = {WORD_W{1'b1}};
        queue_poll(SLOTS_NES, 1'b0, 1'b1);
        wait_quiet();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 28;
            end else if (seg == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_PAD_TYPE,
                      CFG_DATA_W'((seg % 2 == 0) ? PAD_SNES : PAD_NES));
            write_reg(REG_PADS_IN_USE,
                      (seg < 8) ? PADS_W'(seg) : PADS_W'($urandom_range(0, 7)));
            queue_segment();
            wait_quiet();
        end

        $display("covered %0d slot requests, %0d polls and %0d pad results",
                 slots_sent, polls_done, results_seen);
        $display("across %0d register writes, both pad types and pad counts 0 to 7",
                 settings_used);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
